[hw/rtl/stp_pkg.sv]
// stp_pkg: shared types and constants of the segment translate and protect block.
// Used by every module under hw/rtl and by the port checker; depends on nothing.
package stp_pkg;

   localparam int ADDR_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 32;

   localparam int FIELD_W     = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 9 * FIELD_W;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int PERM_W      = 9;
   localparam int PRESENT_W   = 3;

   // access kinds
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_EXEC  = 2'd2;

   // segment selectors
   localparam logic [1:0] SEG_CODE  = 2'd0;
   localparam logic [1:0] SEG_HEAP  = 2'd1;
   localparam logic [1:0] SEG_STACK = 2'd2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_PROT   = 2'd2,
      ST_NOSEG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_CODE_BASE   = 3'd0,
      REG_CODE_LIMIT  = 3'd1,
      REG_HEAP_BASE   = 3'd2,
      REG_HEAP_LIMIT  = 3'd3,
      REG_STACK_BASE  = 3'd4,
      REG_STACK_LIMIT = 3'd5,
      REG_SEG_PERMS   = 3'd6,
      REG_SEG_PRESENT = 3'd7
   } reg_type;

   // counter increments caused by one access
   typedef struct packed {
      logic       access;
      logic       ok;
      logic       bounds;
      logic       prot;
      logic       noseg;
      logic [2:0] hit;
   } bump_type;

endpackage

[hw/rtl/stp_sat_counter.sv]
// stp_sat_counter: saturating event counter with a 32-bit view of its low bits.
// Uses stp_pkg for the field width.
module stp_sat_counter #(
   parameter int COUNT_BITS = stp_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        inc,
   output logic [stp_pkg::FIELD_W-1:0] total
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (inc && (count_ff != {COUNT_BITS{1'b1}})) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   generate
      if (COUNT_BITS >= stp_pkg::FIELD_W) begin : g_trunc
         assign total = count_ff[stp_pkg::FIELD_W-1:0];
      end else begin : g_ext
         assign total = {{(stp_pkg::FIELD_W-COUNT_BITS){1'b0}}, count_ff};
      end
   endgenerate

endmodule

[hw/rtl/stp_xlate.sv]
// stp_xlate: presence, permission and bounds check plus address translation of one access.
// Purely combinational; uses stp_pkg codes and the bump_type struct.
module stp_xlate #(
   parameter int ADDR_BITS = stp_pkg::ADDR_BITS_DEF
) (
   input  logic [1:0]                    cmd,
   input  logic [1:0]                    seg,
   input  logic [31:0]                   offset,
   input  logic [31:0]                   code_base,
   input  logic [31:0]                   code_limit,
   input  logic [31:0]                   heap_base,
   input  logic [31:0]                   heap_limit,
   input  logic [31:0]                   stack_base,
   input  logic [31:0]                   stack_limit,
   input  logic [stp_pkg::PERM_W-1:0]    perms,
   input  logic [stp_pkg::PRESENT_W-1:0] present,
   output stp_pkg::status_type           status,
   output logic [31:0]                   phys_addr,
   output stp_pkg::bump_type             bump
);

   localparam int          PA_KEEP = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam logic [31:0] PA_MASK = 32'hFFFF_FFFF >> (32 - PA_KEEP);

   logic [31:0] sel_base;
   logic [31:0] sel_limit;
   logic [2:0]  sel_perm;
   logic        sel_present;
   logic        allowed;
   logic [31:0] sum;
   logic [31:0] pa_raw;

   always_comb begin
      sel_base    = '0;
      sel_limit   = '0;
      sel_perm    = '0;
      sel_present = 1'b0;
      case (seg)
         stp_pkg::SEG_CODE: begin
            sel_base    = code_base;
            sel_limit   = code_limit;
            sel_perm    = perms[2:0];
            sel_present = present[0];
         end
         stp_pkg::SEG_HEAP: begin
            sel_base    = heap_base;
            sel_limit   = heap_limit;
            sel_perm    = perms[5:3];
            sel_present = present[1];
         end
         stp_pkg::SEG_STACK: begin
            sel_base    = stack_base;
            sel_limit   = stack_limit;
            sel_perm    = perms[8:6];
            sel_present = present[2];
         end
         default: ;
      endcase

      case (cmd)
         stp_pkg::CMD_READ:  allowed = sel_perm[0];
         stp_pkg::CMD_WRITE: allowed = sel_perm[1];
         stp_pkg::CMD_EXEC:  allowed = sel_perm[2];
         default:            allowed = 1'b0;
      endcase

      // stack grows down from its base
      sum    = sel_base + offset;
      pa_raw = (seg == stp_pkg::SEG_STACK) ? (sum - sel_limit) : sum;

      bump      = '0;
      phys_addr = '0;
      if (!sel_present) begin
         status     = stp_pkg::ST_NOSEG;
         bump.noseg = 1'b1;
      end else if (!allowed) begin
         status      = stp_pkg::ST_PROT;
         bump.access = 1'b1;
         bump.prot   = 1'b1;
      end else if (offset >= sel_limit) begin
         status      = stp_pkg::ST_BOUNDS;
         bump.access = 1'b1;
         bump.bounds = 1'b1;
      end else begin
         status       = stp_pkg::ST_OK;
         phys_addr    = pa_raw & PA_MASK;
         bump.access  = 1'b1;
         bump.ok      = 1'b1;
         bump.hit[seg] = 1'b1;
      end
   end

endmodule

[hw/rtl/segment_translate_protect.sv]
// Segment translate and protect: each access (cmd, segment, offset) is checked for a present
// segment, the segment's rwx permission and offset < limit, and translated to base + offset
// (base + offset - limit for the downward growing stack). One access is taken every clock;
// each access passes from the input register through the check and translate logic into
// the result register. The input stalls only while a full result register is held by
// rsp_tready low. Saturating event counters are returned with each result and show the
// counts after that access.
// Depends on stp_pkg, stp_xlate and stp_sat_counter.
module segment_translate_protect #(
   parameter int ADDR_BITS  = stp_pkg::ADDR_BITS_DEF,
   parameter int COUNT_BITS = stp_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stp_pkg::REQ_TDATA_W-1:0]   req_tdata,   // offset
   input  logic [stp_pkg::REQ_TUSER_W-1:0]   req_tuser,   // cmd, segment
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // phys_addr, access_total, ok_total, bounds_total, prot_total, noseg_total,
   // code_hit_total, heap_hit_total, stack_hit_total
   output logic [stp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [stp_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // status
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [stp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [stp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [stp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // configuration
   logic [31:0]                   code_base_ff;
   logic [31:0]                   code_limit_ff;
   logic [31:0]                   heap_base_ff;
   logic [31:0]                   heap_limit_ff;
   logic [31:0]                   stack_base_ff;
   logic [31:0]                   stack_limit_ff;
   logic [stp_pkg::PERM_W-1:0]    perms_ff;
   logic [stp_pkg::PRESENT_W-1:0] present_ff;
   stp_pkg::reg_type              csr_reg;
   logic                          csr_write;

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  in_cmd_ff;
   logic [1:0]  in_seg_ff;
   logic [31:0] in_offset_ff;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   stp_pkg::status_type rsp_status_ff;
   logic [31:0]         rsp_paddr_ff;

   stp_pkg::status_type x_status;
   logic [31:0]         x_paddr;
   stp_pkg::bump_type   x_bump;
   stp_pkg::bump_type   bump_en;
   logic                advance;
   logic                req_xfer;

   logic [31:0] access_total;
   logic [31:0] ok_total;
   logic [31:0] bounds_total;
   logic [31:0] prot_total;
   logic [31:0] noseg_total;
   logic [31:0] code_hit_total;
   logic [31:0] heap_hit_total;
   logic [31:0] stack_hit_total;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_reg    = stp_pkg::reg_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff   <= '0;
         code_limit_ff  <= '0;
         heap_base_ff   <= '0;
         heap_limit_ff  <= '0;
         stack_base_ff  <= '0;
         stack_limit_ff <= '0;
         perms_ff       <= '0;
         present_ff     <= '0;
      end else if (csr_write) begin
         case (csr_reg)
            stp_pkg::REG_CODE_BASE:   code_base_ff   <= csr_pwdata;
            stp_pkg::REG_CODE_LIMIT:  code_limit_ff  <= csr_pwdata;
            stp_pkg::REG_HEAP_BASE:   heap_base_ff   <= csr_pwdata;
            stp_pkg::REG_HEAP_LIMIT:  heap_limit_ff  <= csr_pwdata;
            stp_pkg::REG_STACK_BASE:  stack_base_ff  <= csr_pwdata;
            stp_pkg::REG_STACK_LIMIT: stack_limit_ff <= csr_pwdata;
            stp_pkg::REG_SEG_PERMS:   perms_ff       <= csr_pwdata[stp_pkg::PERM_W-1:0];
            stp_pkg::REG_SEG_PRESENT: present_ff     <= csr_pwdata[stp_pkg::PRESENT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         stp_pkg::REG_CODE_BASE:   csr_prdata = code_base_ff;
         stp_pkg::REG_CODE_LIMIT:  csr_prdata = code_limit_ff;
         stp_pkg::REG_HEAP_BASE:   csr_prdata = heap_base_ff;
         stp_pkg::REG_HEAP_LIMIT:  csr_prdata = heap_limit_ff;
         stp_pkg::REG_STACK_BASE:  csr_prdata = stack_base_ff;
         stp_pkg::REG_STACK_LIMIT: csr_prdata = stack_limit_ff;
         stp_pkg::REG_SEG_PERMS:
            csr_prdata = {{(stp_pkg::CSR_DATA_W-stp_pkg::PERM_W){1'b0}}, perms_ff};
         stp_pkg::REG_SEG_PRESENT:
            csr_prdata = {{(stp_pkg::CSR_DATA_W-stp_pkg::PRESENT_W){1'b0}}, present_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // two-stage flow: an item moves on whenever the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff    <= req_tuser[1:0];
         in_seg_ff    <= req_tuser[3:2];
         in_offset_ff <= req_tdata;
      end
      if (advance) begin
         rsp_status_ff <= x_status;
         rsp_paddr_ff  <= x_paddr;
      end
   end

   stp_xlate #(
      .ADDR_BITS(ADDR_BITS)
   ) u_xlate (
      .cmd        (in_cmd_ff),
      .seg        (in_seg_ff),
      .offset     (in_offset_ff),
      .code_base  (code_base_ff),
      .code_limit (code_limit_ff),
      .heap_base  (heap_base_ff),
      .heap_limit (heap_limit_ff),
      .stack_base (stack_base_ff),
      .stack_limit(stack_limit_ff),
      .perms      (perms_ff),
      .present    (present_ff),
      .status     (x_status),
      .phys_addr  (x_paddr),
      .bump       (x_bump)
   );

   // counters move only when a new result loads, so they match the result on display
   assign bump_en = advance ? x_bump : '0;

   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_access (
      .clock(clock), .reset(reset), .inc(bump_en.access), .total(access_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_ok (
      .clock(clock), .reset(reset), .inc(bump_en.ok), .total(ok_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_bounds (
      .clock(clock), .reset(reset), .inc(bump_en.bounds), .total(bounds_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_prot (
      .clock(clock), .reset(reset), .inc(bump_en.prot), .total(prot_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_noseg (
      .clock(clock), .reset(reset), .inc(bump_en.noseg), .total(noseg_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_code (
      .clock(clock), .reset(reset), .inc(bump_en.hit[0]), .total(code_hit_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_heap (
      .clock(clock), .reset(reset), .inc(bump_en.hit[1]), .total(heap_hit_total));
   stp_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_cnt_stack (
      .clock(clock), .reset(reset), .inc(bump_en.hit[2]), .total(stack_hit_total));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {stack_hit_total, heap_hit_total, code_hit_total, noseg_total,
                        prot_total, bounds_total, ok_total, access_total, rsp_paddr_ff};

endmodule

[hw/rtl/stp_checker.sv]
// stp_checker: port-level checks of segment_translate_protect, attached by bind.
// Depends on stp_pkg for the status codes.
module stp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [stp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [stp_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // faults carry a zero address
   a_fault_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != stp_pkg::ST_OK) |-> rsp_tdata[31:0] == 32'd0)
      else $error("faulting result with nonzero address");

   // the input side only stalls behind a full, stalled result
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind segment_translate_protect stp_checker u_stp_checker (.*);
